// File: rtl/tftp_transfer_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// TFTP transfer sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`define TFTP_TRANSFER_SEQUENCER_TOP_DEFINES_SVH

// Check a property that must hold at every rising clock edge.
`define TTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer package
// Payload types, event and action codes, and shared helper functions.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Event codes carried in the func field
  localparam logic [3:0] FUNC_START     = 4'd0;
  localparam logic [3:0] FUNC_ACK       = 4'd1;
  localparam logic [3:0] FUNC_DATA      = 4'd2;
  localparam logic [3:0] FUNC_TIMEOUT   = 4'd3;
  localparam logic [3:0] FUNC_PEER_ERR  = 4'd4;
  localparam logic [3:0] FUNC_STRANGER  = 4'd5;
  localparam logic [3:0] FUNC_MALFORMED = 4'd6;
  localparam logic [3:0] FUNC_RECV_FAIL = 4'd7;
  localparam logic [3:0] FUNC_WRONG_TYP = 4'd8;
  localparam logic [3:0] FUNC_SHUTDOWN  = 4'd9;

  // Result actions
  localparam logic [2:0] ACT_DATA   = 3'd0;
  localparam logic [2:0] ACT_OACK   = 3'd1;
  localparam logic [2:0] ACT_ACK    = 3'd2;
  localparam logic [2:0] ACT_ERR    = 3'd3;
  localparam logic [2:0] ACT_ACCEPT = 3'd4;
  localparam logic [2:0] ACT_OK     = 3'd5;
  localparam logic [2:0] ACT_FAIL   = 3'd6;

  // Protocol error codes
  localparam logic [2:0] ERR_UNDEF     = 3'd0;
  localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
  localparam logic [2:0] ERR_ACCESS    = 3'd2;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd4;
  localparam logic [2:0] ERR_BAD_TID   = 3'd5;
  localparam logic [2:0] ERR_EXISTS    = 3'd6;

  // Open status codes
  localparam logic [1:0] OPEN_OK        = 2'd0;
  localparam logic [1:0] OPEN_NOT_FOUND = 2'd1;
  localparam logic [1:0] OPEN_ACCESS    = 2'd2;
  localparam logic [1:0] OPEN_EXISTS    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIRECTION = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SZ  = 2'd1;
  localparam logic [1:0] CFG_OPTIONS   = 2'd2;
  localparam logic [1:0] CFG_FILE_LEN  = 2'd3;

  // Block size limits and last block number
  localparam logic [15:0] BS_MIN    = 16'd8;
  localparam logic [15:0] BS_MAX    = 16'd65464;
  localparam logic [15:0] BLOCK_TOP = 16'hFFFF;

  // Result queue depth and the most results one request can cause
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] block_number;
    logic [15:0] data_length;
    logic [1:0]  open_status;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] out_block;
    logic [15:0] out_length;
    logic [2:0]  error_code;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        direction;
    logic [15:0] block_size;
    logic        options_negotiated;
    logic [31:0] file_length;
  } cfg_t;

  // Results of one request, packed for the queue
  typedef struct packed {
    logic [1:0]       num;
    rsp_t [2:0]       item;
  } res_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_WRITE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_OACK,
    KIND_ACK
  } kind_e;

  // Classified outcome of one request
  typedef enum logic [4:0] {
    V_IGNORE,
    V_FAIL_ERR,
    V_FAIL_QUIET,
    V_START_RD_OACK,
    V_START_RD_DATA,
    V_START_WR_OACK,
    V_START_WR_ACK,
    V_ACK_DONE,
    V_ACK_NEXT,
    V_ACK_DUP,
    V_DATA_LAST,
    V_DATA_WRAP,
    V_DATA_NEXT,
    V_DATA_DUP,
    V_RESEND,
    V_TIMEOUT_QUIET,
    V_STRANGER
  } verdict_e;

  function automatic rsp_t mk_item(logic [2:0] act, logic [15:0] blk,
                                   logic [15:0] len, logic [2:0] err);
    rsp_t r;
    r.action     = act;
    r.out_block  = blk;
    r.out_length = len;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [2:0] open_err(logic [1:0] st);
    logic [2:0] e;
    unique case (st)
      OPEN_NOT_FOUND: e = ERR_NOT_FOUND;
      OPEN_ACCESS:    e = ERR_ACCESS;
      OPEN_EXISTS:    e = ERR_EXISTS;
      default:        e = ERR_UNDEF;
    endcase
    return e;
  endfunction

  function automatic logic [15:0] clamp_bs(logic [15:0] bs);
    logic [15:0] r;
    if (bs < BS_MIN) begin
      r = BS_MIN;
    end else if (bs > BS_MAX) begin
      r = BS_MAX;
    end else begin
      r = bs;
    end
    return r;
  endfunction

endpackage

// File: rtl/tts_core.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer core
// Transfer state and the decision logic that turns one request into results.
// ----------------------------------------------------------------------------
`include "tftp_transfer_sequencer_top_defines.svh"

module tts_core #(
  parameter int unsigned MAX_TRIES = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  tts_pkg::req_t req_i,
  input  tts_pkg::cfg_t cfg_i,
  output tts_pkg::res_t res_o
);

  localparam int unsigned TW = $clog2(MAX_TRIES + 1);

  tts_pkg::phase_e   phase_q, phase_d;
  tts_pkg::kind_e    kind_q, kind_d;
  tts_pkg::verdict_e verdict;
  logic [15:0] exp_q, exp_d;
  logic [31:0] left_q, left_d;
  logic [15:0] lblk_q, lblk_d;
  logic [15:0] llen_q, llen_d;
  logic        resend_q, resend_d;
  logic [TW-1:0] tcnt_q, tcnt_d;

  logic        active;
  logic [15:0] bs;
  logic [31:0] limit;
  logic        too_long;
  logic [TW-1:0] tinc;
  logic [31:0] left_sub;
  logic [31:0] left_new;
  logic [15:0] next_len;
  logic [15:0] start_len;
  logic [15:0] exp_inc;
  logic [15:0] exp_dec;
  logic [2:0]  err;

  assign active   = (phase_q == tts_pkg::PH_READ) || (phase_q == tts_pkg::PH_WRITE);
  assign bs       = tts_pkg::clamp_bs(cfg_i.block_size);
  // 65535 * bs, formed as bs * 2^16 - bs
  assign limit    = {bs, 16'd0} - {16'd0, bs};
  assign too_long = cfg_i.file_length >= limit;
  assign tinc     = TW'(tcnt_q + 1'b1);
  assign left_sub = ({16'd0, llen_q} <= left_q) ? (left_q - {16'd0, llen_q}) : 32'd0;
  assign left_new = (kind_q == tts_pkg::KIND_DATA) ? left_sub : left_q;
  assign next_len = (left_new < {16'd0, bs}) ? left_new[15:0] : bs;
  assign start_len = (cfg_i.file_length < {16'd0, bs}) ? cfg_i.file_length[15:0] : bs;
  assign exp_inc  = 16'(exp_q + 16'd1);
  assign exp_dec  = 16'(exp_q - 16'd1);

  // Classify the request
  always_comb begin
    verdict = tts_pkg::V_IGNORE;
    err     = tts_pkg::ERR_UNDEF;
    if (req_i.func == tts_pkg::FUNC_START) begin
      if (!active) begin
        if (req_i.open_status != tts_pkg::OPEN_OK) begin
          verdict = tts_pkg::V_FAIL_ERR;
          err     = tts_pkg::open_err(req_i.open_status);
        end else if (!cfg_i.direction) begin
          if (too_long) begin
            verdict = tts_pkg::V_FAIL_ERR;
          end else if (cfg_i.options_negotiated) begin
            verdict = tts_pkg::V_START_RD_OACK;
          end else begin
            verdict = tts_pkg::V_START_RD_DATA;
          end
        end else if (cfg_i.options_negotiated) begin
          verdict = tts_pkg::V_START_WR_OACK;
        end else begin
          verdict = tts_pkg::V_START_WR_ACK;
        end
      end
    end else if (active) begin
      unique case (req_i.func) inside
        tts_pkg::FUNC_ACK: begin
          if (phase_q != tts_pkg::PH_READ) begin
            verdict = tts_pkg::V_FAIL_ERR;
            err     = tts_pkg::ERR_ILLEGAL;
          end else if (req_i.block_number == exp_q) begin
            if ((kind_q == tts_pkg::KIND_DATA) && (llen_q < bs)) begin
              verdict = tts_pkg::V_ACK_DONE;
            end else if (exp_q == tts_pkg::BLOCK_TOP) begin
              verdict = tts_pkg::V_FAIL_ERR;
            end else begin
              verdict = tts_pkg::V_ACK_NEXT;
            end
          end else if (req_i.block_number > exp_q) begin
            verdict = tts_pkg::V_FAIL_ERR;
            err     = tts_pkg::ERR_ILLEGAL;
          end else begin
            verdict = tts_pkg::V_ACK_DUP;
          end
        end
        tts_pkg::FUNC_DATA: begin
          if (phase_q != tts_pkg::PH_WRITE) begin
            verdict = tts_pkg::V_FAIL_ERR;
            err     = tts_pkg::ERR_ILLEGAL;
          end else if (req_i.block_number == exp_q) begin
            if (req_i.data_length < bs) begin
              verdict = tts_pkg::V_DATA_LAST;
            end else if (exp_q == tts_pkg::BLOCK_TOP) begin
              verdict = tts_pkg::V_DATA_WRAP;
            end else begin
              verdict = tts_pkg::V_DATA_NEXT;
            end
          end else if (req_i.block_number > exp_q) begin
            verdict = tts_pkg::V_FAIL_ERR;
            err     = tts_pkg::ERR_ILLEGAL;
          end else begin
            verdict = tts_pkg::V_DATA_DUP;
          end
        end
        tts_pkg::FUNC_TIMEOUT: begin
          if (tinc >= TW'(MAX_TRIES)) begin
            verdict = tts_pkg::V_FAIL_ERR;
          end else if (resend_q) begin
            verdict = tts_pkg::V_RESEND;
          end else begin
            verdict = tts_pkg::V_TIMEOUT_QUIET;
          end
        end
        tts_pkg::FUNC_PEER_ERR: verdict = tts_pkg::V_FAIL_QUIET;
        tts_pkg::FUNC_STRANGER: verdict = tts_pkg::V_STRANGER;
        tts_pkg::FUNC_MALFORMED, tts_pkg::FUNC_WRONG_TYP: begin
          verdict = tts_pkg::V_FAIL_ERR;
          err     = tts_pkg::ERR_ILLEGAL;
        end
        tts_pkg::FUNC_RECV_FAIL, tts_pkg::FUNC_SHUTDOWN: verdict = tts_pkg::V_FAIL_ERR;
        default: verdict = tts_pkg::V_IGNORE;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    exp_d    = exp_q;
    left_d   = left_q;
    lblk_d   = lblk_q;
    llen_d   = llen_q;
    resend_d = resend_q;
    tcnt_d   = tcnt_q;
    unique case (verdict)
      tts_pkg::V_FAIL_ERR, tts_pkg::V_FAIL_QUIET, tts_pkg::V_DATA_WRAP: begin
        phase_d = tts_pkg::PH_DONE;
      end
      tts_pkg::V_START_RD_OACK, tts_pkg::V_START_RD_DATA: begin
        phase_d  = tts_pkg::PH_READ;
        left_d   = cfg_i.file_length;
        tcnt_d   = '0;
        resend_d = 1'b1;
        if (verdict == tts_pkg::V_START_RD_OACK) begin
          exp_d  = 16'd0;
          kind_d = tts_pkg::KIND_OACK;
          lblk_d = 16'd0;
          llen_d = 16'd0;
        end else begin
          exp_d  = 16'd1;
          kind_d = tts_pkg::KIND_DATA;
          lblk_d = 16'd1;
          llen_d = start_len;
        end
      end
      tts_pkg::V_START_WR_OACK, tts_pkg::V_START_WR_ACK: begin
        phase_d  = tts_pkg::PH_WRITE;
        exp_d    = 16'd1;
        tcnt_d   = '0;
        resend_d = 1'b1;
        kind_d   = (verdict == tts_pkg::V_START_WR_OACK) ? tts_pkg::KIND_OACK
                                                         : tts_pkg::KIND_ACK;
        lblk_d   = 16'd0;
        llen_d   = 16'd0;
      end
      tts_pkg::V_ACK_DONE: phase_d = tts_pkg::PH_DONE;
      tts_pkg::V_ACK_NEXT: begin
        tcnt_d   = '0;
        resend_d = 1'b1;
        left_d   = left_new;
        exp_d    = exp_inc;
        kind_d   = tts_pkg::KIND_DATA;
        lblk_d   = exp_inc;
        llen_d   = next_len;
      end
      tts_pkg::V_ACK_DUP: begin
        tcnt_d   = '0;
        resend_d = 1'b0;
      end
      tts_pkg::V_DATA_LAST: begin
        phase_d = tts_pkg::PH_DONE;
        kind_d  = tts_pkg::KIND_ACK;
        lblk_d  = req_i.block_number;
        llen_d  = 16'd0;
      end
      tts_pkg::V_DATA_NEXT: begin
        tcnt_d = '0;
        exp_d  = exp_inc;
        kind_d = tts_pkg::KIND_ACK;
        lblk_d = req_i.block_number;
        llen_d = 16'd0;
      end
      tts_pkg::V_DATA_DUP: begin
        tcnt_d = '0;
        kind_d = tts_pkg::KIND_ACK;
        lblk_d = exp_dec;
        llen_d = 16'd0;
      end
      tts_pkg::V_RESEND, tts_pkg::V_TIMEOUT_QUIET: tcnt_d = tinc;
      default: ;
    endcase
  end

  // Result items
  always_comb begin
    res_o.num  = 2'd0;
    res_o.item = '0;
    unique case (verdict)
      tts_pkg::V_FAIL_ERR: begin
        res_o.num     = 2'd2;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_ERR, 16'd0, 16'd0, err);
        res_o.item[1] = tts_pkg::mk_item(tts_pkg::ACT_FAIL, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_FAIL_QUIET: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_FAIL, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_START_RD_OACK, tts_pkg::V_START_WR_OACK: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_OACK, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_START_RD_DATA: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_DATA, 16'd1, start_len,
                                         tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_START_WR_ACK: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_ACK, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_ACK_DONE: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_OK, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_ACK_NEXT: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_DATA, exp_inc, next_len,
                                         tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_DATA_LAST, tts_pkg::V_DATA_WRAP, tts_pkg::V_DATA_NEXT: begin
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_ACCEPT, req_i.block_number,
                                         req_i.data_length, tts_pkg::ERR_UNDEF);
        if (verdict == tts_pkg::V_DATA_WRAP) begin
          res_o.num     = 2'd3;
          res_o.item[1] = tts_pkg::mk_item(tts_pkg::ACT_ERR, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
          res_o.item[2] = tts_pkg::mk_item(tts_pkg::ACT_FAIL, 16'd0, 16'd0,
                                           tts_pkg::ERR_UNDEF);
        end else begin
          res_o.num     = (verdict == tts_pkg::V_DATA_LAST) ? 2'd3 : 2'd2;
          res_o.item[1] = tts_pkg::mk_item(tts_pkg::ACT_ACK, req_i.block_number, 16'd0,
                                           tts_pkg::ERR_UNDEF);
          res_o.item[2] = tts_pkg::mk_item(tts_pkg::ACT_OK, 16'd0, 16'd0, tts_pkg::ERR_UNDEF);
        end
      end
      tts_pkg::V_DATA_DUP: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_ACK, exp_dec, 16'd0, tts_pkg::ERR_UNDEF);
      end
      tts_pkg::V_RESEND: begin
        res_o.num = 2'd1;
        case (kind_q)
          tts_pkg::KIND_DATA: res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_DATA, lblk_q,
                                                               llen_q, tts_pkg::ERR_UNDEF);
          tts_pkg::KIND_OACK: res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_OACK, 16'd0,
                                                               16'd0, tts_pkg::ERR_UNDEF);
          default:            res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_ACK, lblk_q,
                                                               16'd0, tts_pkg::ERR_UNDEF);
        endcase
      end
      tts_pkg::V_STRANGER: begin
        res_o.num     = 2'd1;
        res_o.item[0] = tts_pkg::mk_item(tts_pkg::ACT_ERR, 16'd0, 16'd0, tts_pkg::ERR_BAD_TID);
      end
      default: ;
    endcase
    // Mark the final result of this request
    case (res_o.num)
      2'd1:    res_o.item[0].last = 1'b1;
      2'd2:    res_o.item[1].last = 1'b1;
      2'd3:    res_o.item[2].last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tts_pkg::PH_IDLE;
      kind_q   <= tts_pkg::KIND_DATA;
      exp_q    <= 16'd0;
      left_q   <= 32'd0;
      lblk_q   <= 16'd0;
      llen_q   <= 16'd0;
      resend_q <= 1'b1;
      tcnt_q   <= '0;
    end else if (go_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      exp_q    <= exp_d;
      left_q   <= left_d;
      lblk_q   <= lblk_d;
      llen_q   <= llen_d;
      resend_q <= resend_d;
      tcnt_q   <= tcnt_d;
    end
  end

  `TTS_ASSERT_NEXT(a_fail_ends_transfer, go_i && ((res_o.item[0].action == tts_pkg::ACT_FAIL) || (res_o.item[1].action == tts_pkg::ACT_FAIL) || (res_o.item[2].action == tts_pkg::ACT_FAIL)), phase_q == tts_pkg::PH_DONE, "failure did not end the transfer")
  `TTS_ASSERT_ALWAYS(a_tries_bounded, !active || (tcnt_q < TW'(MAX_TRIES)), "timeout count reached limit while active")

endmodule

// File: rtl/tts_outq.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer result queue
// Takes up to three results per cycle, hands one per cycle out while ready.
// ----------------------------------------------------------------------------
`include "tftp_transfer_sequencer_top_defines.svh"

module tts_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tts_pkg::res_t res_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output tts_pkg::rsp_t rsp_o
);

  localparam int unsigned PW = $clog2(tts_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(tts_pkg::QDEPTH + 1);

  tts_pkg::rsp_t mem_q [tts_pkg::QDEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] push_n;
  logic          pop;

  assign push_n  = push_i ? CW'(res_i.num) : '0;
  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign rsp_o   = mem_q[rd_q];
  // Room for a whole request's results, judged from registered count only
  assign room_o  = cnt_q <= CW'(tts_pkg::QDEPTH - tts_pkg::MAX_RES);

  assign wr_d  = PW'(wr_q + push_n[PW-1:0]);
  assign rd_d  = pop ? PW'(rd_q + 1'b1) : rd_q;
  assign cnt_d = CW'(cnt_q + push_n - CW'(pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < tts_pkg::MAX_RES; k++) begin
      if (CW'(k) < push_n) begin
        mem_q[PW'(wr_q + PW'(k))] <= res_i.item[k];
      end
    end
  end

  `TTS_ASSERT_ALWAYS(a_push_fits, (push_n == '0) || (cnt_q <= CW'(tts_pkg::QDEPTH - tts_pkg::MAX_RES)), "result queue overflow")
  `TTS_ASSERT_NEXT(a_count_tracks, 1'b1, cnt_q == CW'($past(cnt_q) + $past(push_n) - CW'($past(pop))), "result queue count mismatch")

endmodule

// File: rtl/tftp_transfer_sequencer_top.sv
// Flow: a request reaches the input register on acceptance; once the queue has room, its
//   results are decided and queued, and the first result is shown from the queue registers.
// Throughput: one request per cycle while the result queue has room for three results;
//   the queue drains one result per cycle while out_ready_i is high, so requests with
//   three results are held back by the single output port of the queue.
// Reset: asynchronous, active low; the transfer goes idle, control registers take defaults.
// ----------------------------------------------------------------------------
// TFTP transfer sequencer
// Server side of one lock-step TFTP read or write transfer: takes packet events,
// emits send, accept and finish actions.
// ----------------------------------------------------------------------------
module tftp_transfer_sequencer_top #(
  parameter int unsigned MAX_TRIES = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Event requests
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tts_pkg::req_t in_req_i,
  // Result stream
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tts_pkg::rsp_t out_rsp_o,
  // Configuration writes
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  // Configuration registers
  tts_pkg::cfg_t cfg_q, cfg_d;

  // Input register: holds one request until the core has taken it
  tts_pkg::req_t req_q;
  logic          req_vld_q, req_vld_d;
  logic          in_acc;
  logic          go;
  logic          room;
  tts_pkg::res_t res;

  // Configuration is always writable
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tts_pkg::CFG_DIRECTION: cfg_d.direction          = cfg_data_i[0];
        tts_pkg::CFG_BLOCK_SZ:  cfg_d.block_size         = cfg_data_i[15:0];
        tts_pkg::CFG_OPTIONS:   cfg_d.options_negotiated = cfg_data_i[0];
        tts_pkg::CFG_FILE_LEN:  cfg_d.file_length        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction          <= 1'b0;
      cfg_q.block_size         <= 16'd512;
      cfg_q.options_negotiated <= 1'b0;
      cfg_q.file_length        <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Advance the held request into the core whenever the queue can take its
  // results; refill the input register in the same cycle.
  assign go         = req_vld_q && room;
  assign in_ready_o = !req_vld_q || go;
  assign in_acc     = in_valid_i && in_ready_o;
  assign req_vld_d  = in_acc ? 1'b1 : (go ? 1'b0 : req_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
  end

  // Decide results and update transfer state
  tts_core #(
    .MAX_TRIES (MAX_TRIES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (req_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Queue results and hand them out one per cycle while out_ready_i is high
  tts_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (go),
    .res_i   (res),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule

// File: sim/tftp_transfer_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer sequencer testbench
// Drives packet events into the sequencer under random idling on both sides,
// predicts every send, accept and finish action with an in-bench model of the
// lock-step transfer, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tftp_transfer_sequencer_top_tb;
  import tts_pkg::*;

  localparam int unsigned TRIES     = 3;
  localparam int unsigned SETTLE    = 6;    // cycles for a request with no result to clear
  localparam int unsigned LONG_HOLD = 300;  // receiver hold-off that backs up the block
  localparam int unsigned N_ITEMS   = 370;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  req_t        in_req_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  tftp_transfer_sequencer_top #(
    .MAX_TRIES(TRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Requests waiting for the driver, and actions the block still owes us
  req_t req_backlog[$];
  rsp_t rsp_due[$];
  rsp_t step_actions[$];

  // Handshakes seen at the last rising edge, read at the following falling edge
  bit req_taken = 1'b0;
  bit rsp_taken = 1'b0;
  bit cfg_taken = 1'b0;

  // Idling control: calm sides never idle; a bump of stall_req asks for a long hold
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  int unsigned stall_req = 0;
  int unsigned stall_seen = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;

  int unsigned queued_count   = 0;
  int unsigned reqs_taken     = 0;
  int unsigned rsps_checked   = 0;
  int unsigned settings_used  = 0;
  int unsigned ok_endings     = 0;
  int unsigned failed_endings = 0;
  int unsigned mismatches     = 0;

  // Register copies, at their reset values
  logic        reg_dir  = 1'b0;
  logic [15:0] reg_bs   = 16'd512;
  logic        reg_opt  = 1'b0;
  logic [31:0] reg_flen = 32'd0;

  // Transfer state, at its reset values
  phase_e      xfer_phase      = PH_IDLE;
  logic [15:0] xfer_expect_blk = '0;
  logic [31:0] xfer_left       = '0;
  kind_e       xfer_kind       = KIND_DATA;
  logic [15:0] xfer_sent_blk   = '0;
  logic [15:0] xfer_sent_len   = '0;
  logic        xfer_resend     = 1'b1;
  logic [3:0]  xfer_timeouts   = '0;

  function automatic int unsigned pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [31:0] eff_block_size(logic [15:0] bs);
    if (bs < BS_MIN) return 32'(BS_MIN);
    if (bs > BS_MAX) return 32'(BS_MAX);
    return 32'(bs);
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer model
  // ---------------------------------------------------------------------------
  task automatic emit_action(input logic [2:0] act, input logic [15:0] blk,
                             input logic [15:0] len, input logic [2:0] err);
    rsp_t a;
    a.action     = act;
    a.out_block  = blk;
    a.out_length = len;
    a.error_code = err;
    a.last       = 1'b0;
    step_actions.push_back(a);
  endtask

  task automatic resend_packet();
    case (xfer_kind)
      KIND_DATA: emit_action(ACT_DATA, xfer_sent_blk, xfer_sent_len, ERR_UNDEF);
      KIND_OACK: emit_action(ACT_OACK, '0, '0, ERR_UNDEF);
      default:   emit_action(ACT_ACK, xfer_sent_blk, '0, ERR_UNDEF);
    endcase
  endtask

  task automatic send_packet(input kind_e kind, input logic [15:0] blk,
                             input logic [15:0] len);
    xfer_kind     = kind;
    xfer_sent_blk = blk;
    xfer_sent_len = len;
    resend_packet();
  endtask

  task automatic abort_transfer(input bit with_err, input logic [2:0] code);
    if (with_err) emit_action(ACT_ERR, '0, '0, code);
    emit_action(ACT_FAIL, '0, '0, ERR_UNDEF);
    xfer_phase = PH_DONE;
  endtask

  // Send the block at the expected number, as much of the file as is left
  task automatic send_next_block(input logic [31:0] bs);
    logic [31:0] len;
    len = (xfer_left < bs) ? xfer_left : bs;
    send_packet(KIND_DATA, xfer_expect_blk, len[15:0]);
  endtask

  // Work out the actions one accepted request causes and queue them as due
  task automatic advance_transfer(input req_t r);
    logic        active;
    logic [31:0] bs;
    logic [31:0] len;
    logic [2:0]  code;
    rsp_t        tail;
    step_actions = {};
    active = (xfer_phase == PH_READ) || (xfer_phase == PH_WRITE);
    bs = eff_block_size(reg_bs);
    if (r.func == FUNC_START) begin
      if (!active) begin
        xfer_timeouts = '0;
        xfer_resend   = 1'b1;
        if (r.open_status != OPEN_OK) begin
          case (r.open_status)
            OPEN_NOT_FOUND: code = ERR_NOT_FOUND;
            OPEN_ACCESS:    code = ERR_ACCESS;
            default:        code = ERR_EXISTS;
          endcase
          abort_transfer(1'b1, code);
        end else if (!reg_dir) begin
          if (reg_flen / bs >= 32'd65535) begin
            // too many blocks for a 16-bit block number
            abort_transfer(1'b1, ERR_UNDEF);
          end else begin
            xfer_phase = PH_READ;
            xfer_left  = reg_flen;
            if (reg_opt) begin
              xfer_expect_blk = '0;
              send_packet(KIND_OACK, '0, '0);
            end else begin
              xfer_expect_blk = 16'd1;
              send_next_block(bs);
            end
          end
        end else begin
          xfer_phase      = PH_WRITE;
          xfer_expect_blk = 16'd1;
          if (reg_opt) send_packet(KIND_OACK, '0, '0);
          else send_packet(KIND_ACK, '0, '0);
        end
      end
    end else if (!active || r.func > FUNC_SHUTDOWN) begin
      // drop: nothing to do outside a transfer, or an unused event code
    end else begin
      case (r.func)
        FUNC_ACK: begin
          xfer_timeouts = '0;
          if (xfer_phase != PH_READ) begin
            abort_transfer(1'b1, ERR_ILLEGAL);
          end else if (r.block_number == xfer_expect_blk) begin
            xfer_resend = 1'b1;
            if (xfer_kind == KIND_DATA) begin
              len = 32'(xfer_sent_len);
              xfer_left = (len <= xfer_left) ? xfer_left - len : '0;
              if (len < bs) begin
                // short block acknowledged: the file is through
                emit_action(ACT_OK, '0, '0, ERR_UNDEF);
                xfer_phase = PH_DONE;
              end
            end
            if (xfer_phase == PH_READ) begin
              if (xfer_expect_blk == BLOCK_TOP) begin
                abort_transfer(1'b1, ERR_UNDEF);
              end else begin
                xfer_expect_blk = xfer_expect_blk + 16'd1;
                send_next_block(bs);
              end
            end
          end else if (r.block_number > xfer_expect_blk) begin
            abort_transfer(1'b1, ERR_ILLEGAL);
          end else begin
            // stale ack: hold timeout resends until the right one shows up
            xfer_resend = 1'b0;
          end
        end
        FUNC_DATA: begin
          xfer_timeouts = '0;
          if (xfer_phase != PH_WRITE) begin
            abort_transfer(1'b1, ERR_ILLEGAL);
          end else if (r.block_number == xfer_expect_blk) begin
            emit_action(ACT_ACCEPT, r.block_number, r.data_length, ERR_UNDEF);
            if (32'(r.data_length) < bs) begin
              send_packet(KIND_ACK, r.block_number, '0);
              emit_action(ACT_OK, '0, '0, ERR_UNDEF);
              xfer_phase = PH_DONE;
            end else if (xfer_expect_blk == BLOCK_TOP) begin
              abort_transfer(1'b1, ERR_UNDEF);
            end else begin
              send_packet(KIND_ACK, r.block_number, '0);
              xfer_expect_blk = xfer_expect_blk + 16'd1;
            end
          end else if (r.block_number > xfer_expect_blk) begin
            abort_transfer(1'b1, ERR_ILLEGAL);
          end else begin
            // duplicate data: acknowledge the last block taken again
            send_packet(KIND_ACK, xfer_expect_blk - 16'd1, '0);
          end
        end
        FUNC_TIMEOUT: begin
          xfer_timeouts = xfer_timeouts + 4'd1;
          if (xfer_timeouts >= TRIES) abort_transfer(1'b1, ERR_UNDEF);
          else if (xfer_resend) resend_packet();
        end
        FUNC_PEER_ERR: abort_transfer(1'b0, ERR_UNDEF);
        FUNC_STRANGER: emit_action(ACT_ERR, '0, '0, ERR_BAD_TID);
        FUNC_MALFORMED, FUNC_WRONG_TYP: abort_transfer(1'b1, ERR_ILLEGAL);
        default: abort_transfer(1'b1, ERR_UNDEF);
      endcase
    end
    if (step_actions.size() > 0) begin
      tail = step_actions.pop_back();
      tail.last = 1'b1;
      step_actions.push_back(tail);
    end
    foreach (step_actions[i]) rsp_due.push_back(step_actions[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      cfg_taken = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rsps_checked++;
        if (out_rsp_o.action == ACT_OK) ok_endings++;
        if (out_rsp_o.action == ACT_FAIL) failed_endings++;
        if (rsp_due.size() == 0) begin
          $error("unpredicted result: action %0d block %0d length %0d error %0d last %0d",
                 out_rsp_o.action, out_rsp_o.out_block, out_rsp_o.out_length,
                 out_rsp_o.error_code, out_rsp_o.last);
          mismatches++;
        end else begin
          want = rsp_due.pop_front();
          check_field("action", want.action, out_rsp_o.action);
          check_field("out_block", want.out_block, out_rsp_o.out_block);
          check_field("out_length", want.out_length, out_rsp_o.out_length);
          check_field("error_code", want.error_code, out_rsp_o.error_code);
          check_field("last", want.last, out_rsp_o.last);
        end
      end
      if (in_valid_i && in_ready_o) begin
        reqs_taken++;
        advance_transfer(in_req_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DIRECTION: reg_dir  = cfg_data_i[0];
          CFG_BLOCK_SZ:  reg_bs   = cfg_data_i[15:0];
          CFG_OPTIONS:   reg_opt  = cfg_data_i[0];
          default:       reg_flen = cfg_data_i;
        endcase
      end
      req_taken = in_valid_i && in_ready_o;
      rsp_taken = out_valid_o && out_ready_i;
      cfg_taken = cfg_valid_i && cfg_ready_o;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: hold each request until taken, then idle a drawn number of cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (in_valid_i) tx_gap = pick_gap(calm_tx);
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_req_i   <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: draw a wait per result; a stall request holds ready low for long
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        rx_hold    = LONG_HOLD;
      end
      if (rsp_taken) rx_gap = pick_gap(calm_rx);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [3:0] func, input logic [15:0] blk,
                           input logic [15:0] dlen, input logic [1:0] st);
    req_t r;
    r.func         = func;
    r.block_number = blk;
    r.data_length  = dlen;
    r.open_status  = st;
    req_backlog.push_back(r);
    queued_count++;
  endtask

  // Wait until every request is taken and every due result has arrived
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || rsp_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Must only run from a falling edge; leaves valid high for the next write
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (!cfg_taken);
  endtask

  task automatic set_config(input logic dir, input logic [15:0] bs, input logic opt,
                            input logic [31:0] flen);
    wait_drained();
    calm_tx = ($urandom_range(0, 3) == 0);
    calm_rx = ($urandom_range(0, 3) == 0);
    @(negedge clk_i);
    cfg_write(CFG_DIRECTION, {31'd0, dir});
    cfg_write(CFG_BLOCK_SZ, {16'd0, bs});
    cfg_write(CFG_OPTIONS, {31'd0, opt});
    cfg_write(CFG_FILE_LEN, flen);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Occasional noise between the well-formed steps of a transfer
  task automatic queue_noise(input int unsigned next_blk, input logic dir);
    int unsigned roll;
    int unsigned count;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      count = (roll == 0) ? TRIES : $urandom_range(1, TRIES - 1);
      repeat (count) queue_req(FUNC_TIMEOUT, 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65464)), 2'($urandom_range(0, 3)));
    end else if (roll < 14 && next_blk > 0) begin
      queue_req(dir ? FUNC_DATA : FUNC_ACK, 16'($urandom_range(0, next_blk - 1)),
                16'($urandom_range(0, 65464)), OPEN_OK);
    end else if (roll < 18) begin
      queue_req(FUNC_STRANGER, 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65464)), 2'($urandom_range(0, 3)));
    end else if (roll < 20) begin
      queue_req(4'($urandom_range(1, 15)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65464)), 2'($urandom_range(0, 3)));
    end
  endtask

  // One transfer with random settings: mostly in order, sometimes cut short
  task automatic queue_random_transfer();
    int unsigned roll;
    int unsigned nblk;
    int unsigned blk;
    int unsigned sent;
    int unsigned limit;
    logic        dir;
    logic        opt;
    logic [15:0] bs;
    logic [31:0] bs_eff;
    logic [31:0] flen;
    logic [3:0]  closer;
    dir  = 1'($urandom_range(0, 1));
    opt  = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 9);
    if (roll < 7) bs = 16'($urandom_range(8, 64));
    else if (roll == 7) bs = 16'($urandom_range(0, 7));
    else bs = 16'($urandom_range(0, 65535));
    bs_eff = eff_block_size(bs);
    roll = $urandom_range(0, 9);
    if (roll < 6) flen = $urandom_range(0, 5 * bs_eff);
    else if (roll < 9) flen = bs_eff * $urandom_range(0, 4);
    else flen = $urandom;
    set_config(dir, bs, opt, flen);
    if ($urandom_range(0, 9) == 0) begin
      queue_req(FUNC_START, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65464)),
                2'($urandom_range(1, 3)));
    end else begin
      queue_req(FUNC_START, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65464)),
                OPEN_OK);
      limit = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 8;
      sent  = 0;
      if (!dir) begin
        nblk = (flen / bs_eff >= 65535) ? 0 : flen / bs_eff + 1;
        blk  = opt ? 0 : 1;
        while (blk <= nblk && sent < limit) begin
          queue_noise(blk, dir);
          queue_req(FUNC_ACK, 16'(blk), 16'($urandom_range(0, 65464)),
                    2'($urandom_range(0, 3)));
          blk++;
          sent++;
        end
      end else begin
        nblk = $urandom_range(1, 6);
        blk  = 1;
        while (blk <= nblk && sent < limit) begin
          queue_noise(blk, dir);
          queue_req(FUNC_DATA, 16'(blk),
                    (blk == nblk) ? 16'($urandom_range(0, bs_eff - 1)) : bs_eff[15:0],
                    2'($urandom_range(0, 3)));
          blk++;
          sent++;
        end
      end
      // Close a transfer that was cut short so the next start is not dropped
      if (blk <= nblk) begin
        case ($urandom_range(0, 4))
          0:       closer = FUNC_PEER_ERR;
          1:       closer = FUNC_RECV_FAIL;
          2:       closer = FUNC_SHUTDOWN;
          3:       closer = FUNC_MALFORMED;
          default: closer = FUNC_WRONG_TYP;
        endcase
        queue_req(closer, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65464)),
                  2'($urandom_range(0, 3)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: empty file read; ack while idle, start while active, event after done
    queue_req(FUNC_ACK, 16'd1, '0, OPEN_OK);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_ACK, 16'd1, '0, OPEN_OK);
    queue_req(FUNC_TIMEOUT, '0, '0, OPEN_OK);

    // Read with options, block size below the minimum; stale ack mutes resends
    set_config(1'b0, 16'd0, 1'b1, 32'd12);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_TIMEOUT, '0, '0, OPEN_OK);
    queue_req(FUNC_ACK, 16'd0, '0, OPEN_OK);
    queue_req(FUNC_ACK, 16'd0, '0, OPEN_OK);
    queue_req(FUNC_TIMEOUT, '0, '0, OPEN_OK);
    queue_req(FUNC_ACK, 16'd1, '0, OPEN_OK);
    queue_req(FUNC_ACK, 16'd2, '0, OPEN_OK);

    // Write with block size above the maximum: open failures, full block,
    // duplicate, stranger, and timeouts until the retry limit
    set_config(1'b1, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    queue_req(FUNC_START, '0, '0, OPEN_EXISTS);
    queue_req(FUNC_START, '0, '0, OPEN_NOT_FOUND);
    queue_req(FUNC_START, '0, '0, OPEN_ACCESS);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_DATA, 16'd1, BS_MAX, OPEN_OK);
    queue_req(FUNC_DATA, 16'd0, 16'd5, OPEN_OK);
    queue_req(FUNC_STRANGER, 16'hFFFF, BS_MAX, OPEN_EXISTS);
    repeat (TRIES) queue_req(FUNC_TIMEOUT, '0, '0, OPEN_OK);

    // Smallest file that needs too many blocks
    set_config(1'b0, 16'd8, 1'b0, 32'd524280);
    queue_req(FUNC_START, '0, '0, OPEN_OK);

    // Largest block size; malformed, shutdown and peer-error aborts, an unused code, a later ack
    set_config(1'b0, BS_MAX, 1'b0, 32'd524279);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_MALFORMED, '0, '0, OPEN_OK);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_SHUTDOWN, '0, '0, OPEN_OK);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(FUNC_PEER_ERR, '0, '0, OPEN_OK);
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    queue_req(4'hF, 16'hFFFF, BS_MAX, OPEN_EXISTS);
    queue_req(FUNC_ACK, 16'hFFFF, '0, OPEN_OK);

    // Back-pressure: hold the receiver off while strangers pile up results
    set_config(1'b1, 16'd8, 1'b1, 32'd0);
    calm_tx = 1'b1;
    stall_req++;
    queue_req(FUNC_START, '0, '0, OPEN_OK);
    repeat (24) queue_req(FUNC_STRANGER, 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65464)), 2'($urandom_range(0, 3)));
    queue_req(FUNC_DATA, 16'd1, 16'd3, OPEN_OK);

    while (queued_count < N_ITEMS) queue_random_transfer();

    wait_drained();
    $display("Ran %0d requests and checked %0d results under %0d register settings",
             reqs_taken, rsps_checked, settings_used);
    $display("Transfers ended: %0d completed, %0d failed", ok_endings, failed_endings);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
